// ===== src/numeric_format_converter_top_assert.svh =====
// Assertion macros for the numeric format converter.
`ifndef NUMERIC_FORMAT_CONVERTER_TOP_ASSERT_SVH
`define NUMERIC_FORMAT_CONVERTER_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define NFC_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication checked on every clock edge outside reset.
`define NFC_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== src/nfc_pkg.sv =====
// Shared kinds, decode record and mask helper for the numeric format converter.
package nfc_pkg;
    localparam logic [2:0] KIND_I8  = 3'd0;
    localparam logic [2:0] KIND_I16 = 3'd1;
    localparam logic [2:0] KIND_I32 = 3'd2;
    localparam logic [2:0] KIND_F32 = 3'd3;
    localparam logic [2:0] KIND_F64 = 3'd4;

    typedef enum logic [1:0] {
        PATH_DIRECT = 2'd0,
        PATH_TO_FLT = 2'd1,
        PATH_TO_INT = 2'd2
    } t_path;

    // Decoded source, all values held as binary64 fields or a final word.
    typedef struct packed {
        t_path       path;
        logic [2:0]  dkind;
        logic        ovf;
        logic [63:0] direct;
        logic        sign;
        logic [10:0] exp;
        logic [52:0] sig;
        logic        is_zero;
        logic        is_inf;
        logic        is_nan;
        logic [51:0] frac;
    } t_dec;

    function automatic logic [63:0] kind_mask(input logic [2:0] k);
        logic [63:0] m;
        m = '1;
        unique case (k)
            KIND_I8:          m = 64'h0000_0000_0000_00FF;
            KIND_I16:         m = 64'h0000_0000_0000_FFFF;
            KIND_I32, KIND_F32: m = 64'h0000_0000_FFFF_FFFF;
            default:          m = '1;
        endcase
        return m;
    endfunction
endpackage

// ===== src/nfc_decode.sv =====
// Stage 1: classify the request and unpack the source into binary64 fields.
module nfc_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [63:0]         i_bits,
    input  logic [2:0]          i_skind,
    input  logic [2:0]          i_dkind,
    output logic                o_valid,
    output nfc_pkg::t_dec       o_dec
);
    import nfc_pkg::*;

    logic        r_valid;
    t_dec        r_dec, n_dec;
    logic [31:0] ival;
    logic [31:0] imag;
    logic [5:0]  lz;
    logic [4:0]  lzf;
    logic [22:0] fnorm;

    always_comb begin
        unique case (i_skind)
            KIND_I8:  ival = {{24{i_bits[7]}}, i_bits[7:0]};
            KIND_I16: ival = {{16{i_bits[15]}}, i_bits[15:0]};
            default:  ival = i_bits[31:0];
        endcase
        imag = ival[31] ? (~ival + 32'd1) : ival;
        lz = 6'd32;
        for (int k = 0; k < 32; k++) begin
            if (imag[k]) lz = 6'(31 - k);
        end
        lzf = 5'd23;
        for (int k = 0; k < 23; k++) begin
            if (i_bits[k]) lzf = 5'(22 - k);
        end
        fnorm = i_bits[22:0] << lzf;
    end

    always_comb begin
        n_dec         = '0;
        n_dec.dkind   = i_dkind;
        n_dec.path    = PATH_DIRECT;
        if (i_skind > KIND_F64 || i_dkind > KIND_F64) begin
            n_dec.ovf = 1'b1;
        end else if (i_skind == i_dkind) begin
            n_dec.direct = i_bits & kind_mask(i_dkind);
        end else begin
            n_dec.path = (i_dkind >= KIND_F32) ? PATH_TO_FLT : PATH_TO_INT;
            if (i_skind == KIND_F64) begin
                n_dec.sign    = i_bits[63];
                n_dec.is_nan  = (i_bits[62:52] == '1) && (i_bits[51:0] != '0);
                n_dec.is_inf  = (i_bits[62:52] == '1) && (i_bits[51:0] == '0);
                n_dec.is_zero = (i_bits[62:0] == '0);
                n_dec.exp     = i_bits[62:52];
                n_dec.sig     = {(i_bits[62:52] != '0), i_bits[51:0]};
                n_dec.frac    = i_bits[51:0];
            end else if (i_skind == KIND_F32) begin
                n_dec.sign    = i_bits[31];
                n_dec.is_nan  = (i_bits[30:23] == '1) && (i_bits[22:0] != '0);
                n_dec.is_inf  = (i_bits[30:23] == '1) && (i_bits[22:0] == '0);
                n_dec.is_zero = (i_bits[30:0] == '0);
                n_dec.frac    = {i_bits[22:0], 29'd0};
                if (i_bits[30:23] == '0) begin
                    // subnormal binary32 is a normal binary64
                    n_dec.exp  = 11'd896 - {6'd0, lzf};
                    n_dec.sig  = {fnorm, 30'd0};
                    n_dec.frac = n_dec.sig[51:0];
                end else begin
                    n_dec.exp = {3'd0, i_bits[30:23]} + 11'd896;
                    n_dec.sig = {1'b1, i_bits[22:0], 29'd0};
                end
                if (i_bits[30:23] == '1) n_dec.exp = '1;
                if (n_dec.is_nan) n_dec.frac[51] = 1'b1;
            end else begin
                n_dec.sign    = ival[31];
                n_dec.is_zero = (ival == '0);
                n_dec.exp     = 11'd1023 + 11'd31 - {5'd0, lz};
                n_dec.sig     = {imag << lz, 21'd0};
                n_dec.frac    = n_dec.sig[51:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) r_dec <= n_dec;
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;
endmodule

// ===== src/nfc_shift.sv =====
// Stage 2: align the significand for integer truncation or binary32 rounding.
module nfc_shift (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  nfc_pkg::t_dec       i_dec,
    output logic                o_valid,
    output nfc_pkg::t_dec       o_dec,
    output logic [31:0]         o_imag,
    output logic                o_ibig,
    output logic                o_ifrac,
    output logic [25:0]         o_fsig,
    output logic                o_fsticky,
    output logic [7:0]          o_fexp,
    output logic                o_fhuge
);
    import nfc_pkg::*;

    logic        r_valid;
    t_dec        r_dec;
    logic [31:0] r_imag, n_imag;
    logic        r_ibig, n_ibig;
    logic        r_ifrac, n_ifrac;
    logic [25:0] r_fsig, n_fsig;
    logic        r_fst, n_fst;
    logic [7:0]  r_fexp, n_fexp;
    logic        r_fhuge, n_fhuge;
    logic [10:0] ish;
    logic [11:0] ue;
    logic [11:0] rsh;
    logic [52:0] tmp;
    logic [52:0] lost;

    always_comb begin
        // integer: magnitude = sig >> (1075 - exp), only exp 1023..1054 matter
        n_ibig  = (i_dec.exp > 11'd1054);
        n_imag  = '0;
        n_ifrac = 1'b0;
        ish     = 11'd1075 - i_dec.exp;
        if (i_dec.exp >= 11'd1023 && !n_ibig) begin
            n_imag  = 32'(i_dec.sig >> ish);
            n_ifrac = ((i_dec.sig & ~({53{1'b1}} << ish)) != '0);
        end
        // binary32: keep 24 bits plus guard, rest sticky
        ue      = {1'b0, i_dec.exp};
        n_fhuge = (ue >= 12'd1151);
        n_fexp  = '0;
        rsh     = 12'd28;
        if (ue > 12'd896) begin
            n_fexp = 8'(ue - 12'd896);
        end else begin
            rsh = 12'd28 + (12'd897 - ue);
        end
        if (rsh > 12'd54) rsh = 12'd54;
        tmp   = i_dec.sig >> rsh;
        lost  = i_dec.sig & ~('1 << rsh);
        n_fsig = tmp[25:0];
        n_fst  = (lost != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_dec   <= i_dec;
            r_imag  <= n_imag;
            r_ibig  <= n_ibig;
            r_ifrac <= n_ifrac;
            r_fsig  <= n_fsig;
            r_fst   <= n_fst;
            r_fexp  <= n_fexp;
            r_fhuge <= n_fhuge;
        end
    end

    assign o_valid   = r_valid;
    assign o_dec     = r_dec;
    assign o_imag    = r_imag;
    assign o_ibig    = r_ibig;
    assign o_ifrac   = r_ifrac;
    assign o_fsig    = r_fsig;
    assign o_fsticky = r_fst;
    assign o_fexp    = r_fexp;
    assign o_fhuge   = r_fhuge;
endmodule

// ===== src/nfc_pack.sv =====
// Stage 3: round, range-check and pack the destination word.
module nfc_pack (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  nfc_pkg::t_dec       i_dec,
    input  logic [31:0]         i_imag,
    input  logic                i_ibig,
    input  logic                i_ifrac,
    input  logic [25:0]         i_fsig,
    input  logic                i_fsticky,
    input  logic [7:0]          i_fexp,
    input  logic                i_fhuge,
    output logic                o_valid,
    output logic [63:0]         o_bits,
    output logic                o_ovf
);
    import nfc_pkg::*;

    logic        r_valid;
    logic [63:0] r_bits, n_bits;
    logic        r_ovf, n_ovf;
    logic [32:0] sval;
    logic        fits;
    logic [24:0] rsig;
    logic        up;
    logic [8:0]  rexp;
    logic [31:0] f32;

    always_comb begin
        n_bits = '0;
        n_ovf  = 1'b0;
        sval   = i_dec.sign ? (~{1'b0, i_imag} + 33'd1) : {1'b0, i_imag};
        unique case (i_dec.dkind)
            KIND_I8:  fits = i_dec.sign ? (i_imag <= 32'd128) : (i_imag <= 32'd127);
            KIND_I16: fits = i_dec.sign ? (i_imag <= 32'd32768) : (i_imag <= 32'd32767);
            // a fraction beyond the 32-bit bound is out of range
            default:  fits = i_dec.sign
                ? (i_imag < 32'h8000_0000 || (i_imag == 32'h8000_0000 && !i_ifrac))
                : (i_imag < 32'h7FFF_FFFF || (i_imag == 32'h7FFF_FFFF && !i_ifrac));
        endcase
        up   = i_fsig[0] && (i_fsticky || i_fsig[1]);
        rsig = {1'b0, i_fsig[24:1]} + {24'd0, up};
        rexp = {1'b0, i_fexp};
        if (rsig[24]) begin
            rexp = rexp + 9'd1;
        end else if (i_fexp == '0 && rsig[23]) begin
            rexp = 9'd1;
        end
        if (i_dec.is_nan) begin
            f32 = {i_dec.sign, 8'hFF, 1'b1, i_dec.frac[50:29]};
        end else if (i_dec.is_inf || i_fhuge || rexp >= 9'd255) begin
            f32 = {i_dec.sign, 8'hFF, 23'd0};
        end else if (i_dec.is_zero) begin
            f32 = {i_dec.sign, 31'd0};
        end else begin
            f32 = {i_dec.sign, rexp[7:0], rsig[22:0]};
        end
        unique case (i_dec.path)
            PATH_DIRECT: begin
                n_bits = i_dec.direct;
                n_ovf  = i_dec.ovf;
            end
            PATH_TO_FLT: begin
                if (i_dec.dkind == KIND_F32) begin
                    n_bits = {32'd0, f32};
                end else begin
                    n_bits = {i_dec.sign, i_dec.exp, i_dec.frac};
                    if (i_dec.is_zero) n_bits = {i_dec.sign, 63'd0};
                end
            end
            default: begin
                if (i_dec.is_nan || i_dec.is_inf || i_ibig || !fits) begin
                    n_ovf = 1'b1;
                end else begin
                    n_bits = {{31{sval[32]}}, sval} & kind_mask(i_dec.dkind);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_bits <= n_bits;
            r_ovf  <= n_ovf;
        end
    end

    assign o_valid = r_valid;
    assign o_bits  = r_bits;
    assign o_ovf   = r_ovf;
endmodule

// ===== src/numeric_format_converter_top.sv =====
// Top level of the numeric format converter.
//   channel  dir  handshake                 word
//   input    in   i_valid / o_stall         i_source_bits, i_source_kind, i_dest_kind
//   result   out  o_valid / i_stall         o_result_bits, o_overflow
// Three register stages: decode, align, round and pack.
// One word per cycle is accepted while the pipeline moves.
// A held output word stalls every stage, bubbles included.
// Synchronous active-low reset clears the stage valid bits.
module numeric_format_converter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_source_bits,
    input  logic [2:0]  i_source_kind,
    input  logic [2:0]  i_dest_kind,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_result_bits,
    output logic        o_overflow
);
    import nfc_pkg::*;
    `include "numeric_format_converter_top_assert.svh"

    logic        en;
    logic        v1, v2;
    t_dec        d1, d2;
    logic [31:0] imag;
    logic        ibig, ifrac, fst, fhuge;
    logic [25:0] fsig;
    logic [7:0]  fexp;

    // the pipe advances unless the output word is held
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    nfc_decode u_dec (
        .i_clk, .i_rst_n, .i_en(en), .i_valid,
        .i_bits(i_source_bits), .i_skind(i_source_kind), .i_dkind(i_dest_kind),
        .o_valid(v1), .o_dec(d1)
    );

    nfc_shift u_sh (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(v1), .i_dec(d1),
        .o_valid(v2), .o_dec(d2), .o_imag(imag), .o_ibig(ibig), .o_ifrac(ifrac),
        .o_fsig(fsig), .o_fsticky(fst), .o_fexp(fexp), .o_fhuge(fhuge)
    );

    nfc_pack u_pk (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(v2), .i_dec(d2),
        .i_imag(imag), .i_ibig(ibig), .i_ifrac(ifrac), .i_fsig(fsig), .i_fsticky(fst),
        .i_fexp(fexp), .i_fhuge(fhuge),
        .o_valid, .o_bits(o_result_bits), .o_ovf(o_overflow)
    );

    `NFC_ASSERT_IMP(a_ovf_zero, i_clk, i_rst_n, o_valid && o_overflow, o_result_bits == '0)
    `NFC_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_result_bits) && $stable(o_overflow))
    `NFC_ASSERT_NXT(a_fill, i_clk, i_rst_n, !o_stall && v2, o_valid)
endmodule

// ===== test/numeric_format_converter_top_tb.sv =====
// Self-checking testbench for the numeric format converter: directed and random words.
module numeric_format_converter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import nfc_pkg::*;

    localparam logic [2:0] KIND_BAD = 3'd7;
    localparam int unsigned IDLE_PCT = 23;
    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned RANDOM_WORDS = 930;

    typedef struct packed {
        logic [63:0] bits;
        logic        ovf;
    } t_conv;

    class conv_scoreboard;
        t_conv pending[$];
        int unsigned errors;

        function automatic logic [63:0] int_of(logic [63:0] b, logic [2:0] k);
            logic [63:0] v;
            if (k == KIND_I8) v = {{56{b[7]}}, b[7:0]};
            else if (k == KIND_I16) v = {{48{b[15]}}, b[15:0]};
            else v = {{32{b[31]}}, b[31:0]};
            return v;
        endfunction

        function automatic logic [63:0] width_mask(logic [2:0] k);
            if (k == KIND_I8) return 64'hFF;
            if (k == KIND_I16) return 64'hFFFF;
            if (k == KIND_I32 || k == KIND_F32) return 64'hFFFF_FFFF;
            return '1;
        endfunction

        function automatic logic [63:0] int_to_f64(logic [63:0] v);
            logic        s;
            logic [63:0] mag;
            logic [63:0] sh;
            int          p;
            s = v[63];
            mag = s ? -v : v;
            if (mag == 0) return 64'd0;
            p = 0;
            for (int i = 0; i < 64; i++) if (mag[i]) p = i;
            sh = mag << (52 - p);
            return {s, 11'(1023 + p), sh[51:0]};
        endfunction

        function automatic logic [63:0] widen_f32(logic [31:0] w);
            logic [22:0] fr;
            logic [63:0] sh;
            int          p;
            fr = w[22:0];
            if (w[30:23] == 8'hFF) begin
                if (fr == 0) return {w[31], 11'h7FF, 52'd0};
                return {w[31], 11'h7FF, 1'b1, fr[21:0], 29'd0};
            end
            if (w[30:23] == 0) begin
                if (fr == 0) return {w[31], 63'd0};
                p = 0;
                for (int i = 0; i < 23; i++) if (fr[i]) p = i;
                sh = 64'(fr) << (52 - p);
                return {w[31], 11'(p - 149 + 1023), sh[51:0]};
            end
            return {w[31], 11'(int'(w[30:23]) - 127 + 1023), fr, 29'd0};
        endfunction

        function automatic logic [31:0] narrow_f64(logic [63:0] d);
            logic        s;
            logic [63:0] sig, m, rem, half;
            int          e, sh;
            s = d[63];
            if (d[62:52] == 11'h7FF) begin
                if (d[51:0] != 0) return {s, 9'h1FF, d[50:29]};
                return {s, 8'hFF, 23'd0};
            end
            if (d[62:52] == 0) return {s, 31'd0};
            e = int'(d[62:52]) - 1023;
            sig = {11'd0, 1'b1, d[51:0]};
            sh = (e >= -126) ? 29 : 29 + (-126 - e);
            if (sh > 54) return {s, 31'd0};
            m = sig >> sh;
            rem = sig & ((64'd1 << sh) - 1);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && m[0])) m = m + 1;
            if (e >= -126) begin
                if (m == 64'd1 << 24) begin
                    m = 64'd1 << 23;
                    e = e + 1;
                end
                if (e > 127) return {s, 8'hFF, 23'd0};
                return {s, 8'(e + 127), m[22:0]};
            end
            return {s, m[30:0]};
        endfunction

        // truncates toward zero; returns 1 for NaN, outside the signed 32-bit range, or at its bound with a fraction
        function automatic logic f64_to_int(logic [63:0] d, output logic [63:0] v);
            logic [63:0] sig, mag;
            logic        fnz;
            int          e;
            v = 0;
            if (d[62:52] == 11'h7FF) return 1'b1;
            if (d[62:52] == 0) return 1'b0;
            e = int'(d[62:52]) - 1023;
            if (e < 0) return 1'b0;
            if (e >= 32) return 1'b1;
            sig = {11'd0, 1'b1, d[51:0]};
            mag = sig >> (52 - e);
            fnz = (sig & ((64'd1 << (52 - e)) - 1)) != 0;
            if (!d[63] && (mag > 64'h7FFF_FFFF || (mag == 64'h7FFF_FFFF && fnz))) return 1'b1;
            if (d[63] && (mag > 64'h8000_0000 || (mag == 64'h8000_0000 && fnz))) return 1'b1;
            v = d[63] ? -mag : mag;
            return 1'b0;
        endfunction

        function automatic t_conv convert(logic [63:0] b, logic [2:0] sk, logic [2:0] dk);
            t_conv       r;
            logic [63:0] d, v;
            logic        bad;
            r = '0;
            if (sk > KIND_F64 || dk > KIND_F64) begin
                r.ovf = 1'b1;
            end else if (sk == dk) begin
                r.bits = b & width_mask(dk);
            end else begin
                if (sk == KIND_F32) d = widen_f32(b[31:0]);
                else if (sk == KIND_F64) d = b;
                else d = int_to_f64(int_of(b, sk));
                if (dk == KIND_F64) begin
                    r.bits = d;
                end else if (dk == KIND_F32) begin
                    r.bits = {32'd0, narrow_f64(d)};
                end else begin
                    if (sk >= KIND_F32) bad = f64_to_int(d, v);
                    else begin
                        bad = 1'b0;
                        v = int_of(b, sk);
                    end
                    if (!bad) begin
                        if (dk == KIND_I8) bad = $signed(v) < -128 || $signed(v) > 127;
                        else if (dk == KIND_I16) bad = $signed(v) < -32768 || $signed(v) > 32767;
                    end
                    if (bad) r.ovf = 1'b1;
                    else r.bits = v & width_mask(dk);
                end
            end
            return r;
        endfunction

        function void note_input(logic [63:0] b, logic [2:0] sk, logic [2:0] dk);
            pending.push_back(convert(b, sk, dk));
        endfunction

        function void check_result(logic [63:0] bits, logic ovf);
            t_conv want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word bits=%h ovf=%b", $time, bits, ovf);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (bits !== want.bits) begin
                $display("%0t: result_bits expected %h actual %h", $time, want.bits, bits);
                errors++;
            end
            if (ovf !== want.ovf) begin
                $display("%0t: overflow expected %b actual %b", $time, want.ovf, ovf);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [63:0] i_source_bits;
    logic [2:0]  i_source_kind;
    logic [2:0]  i_dest_kind;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_result_bits;
    logic        o_overflow;

    numeric_format_converter_top uut (.*);

    conv_scoreboard sb = new();
    logic        idle_on = 1'b1;
    logic        in_take, out_take;
    logic [63:0] out_bits;
    logic        out_ovf;
    int unsigned quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_source_bits = '0;
        i_source_kind = KIND_I8;
        i_dest_kind = KIND_I8;
        in_take = 1'b0;
        out_take = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(negedge i_clk) begin
        in_take = i_rst_n && i_valid && !o_stall;
        out_take = i_rst_n && o_valid && !i_stall;
        out_bits = o_result_bits;
        out_ovf = o_overflow;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            i_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
            if (out_take) sb.check_result(out_bits, out_ovf);
            if (in_take || out_take) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL numeric_format_converter_top");
                $finish;
            end
        end
    end

    task automatic send_word(logic [63:0] b, logic [2:0] sk, logic [2:0] dk);
        logic take;
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_source_bits <= b;
        i_source_kind <= sk;
        i_dest_kind <= dk;
        do begin
            @(negedge i_clk);
            take = !o_stall;
            @(posedge i_clk);
        end while (!take);
        sb.note_input(b, sk, dk);
    endtask

    function automatic logic [2:0] pick_kind();
        if ($urandom_range(99) < 4) return 3'($urandom_range(7, 5));
        return 3'($urandom_range(4));
    endfunction

    // random upper bits, with the live field often pushed toward edges
    function automatic logic [63:0] pick_bits(logic [2:0] sk);
        logic [63:0] b;
        int unsigned sel;
        b = {$urandom, $urandom};
        sel = $urandom_range(9);
        if (sk == KIND_F32 && sel < 6) begin
            case (sel)
                0: b[30:23] = 8'hFF;
                1: b[30:23] = 8'h00;
                2: b[30:23] = 8'(127 + $urandom_range(33, 0));
                default: b[30:23] = 8'(127 + $urandom_range(10) - 3);
            endcase
            if (sel == 0 && $urandom_range(1)) b[22:0] = 0;
        end else if (sk == KIND_F64 && sel < 7) begin
            case (sel)
                0: b[62:52] = 11'h7FF;
                1: b[62:52] = 11'h000;
                2: b[62:52] = 11'(1023 + $urandom_range(33, 0));
                3: b[62:52] = 11'(1023 + 127 + $urandom_range(2));
                4: b[62:52] = 11'(1023 - 150 + $urandom_range(26));
                default: b[62:52] = 11'(1023 + $urandom_range(12) - 3);
            endcase
            if (sel == 0 && $urandom_range(1)) b[51:0] = 0;
            if (sel == 3 && $urandom_range(1)) b[51:28] = '1;
        end else if (sk <= KIND_I32 && sel < 4) begin
            b[31:0] = 32'($urandom_range(300)) - 32'd150;
            if (sel == 1) b[31:0] = {$urandom_range(1) ? 1'b1 : 1'b0, 31'd0} - 32'd1 + 32'($urandom_range(2));
        end
        return b;
    endfunction

    initial begin
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        send_word(64'hFFFF_FFFF_FFFF_FF80, KIND_I8, KIND_I16);
        send_word(64'h0000_0000_7FFF_FFFF, KIND_I32, KIND_I8);
        send_word(64'hAAAA_5555_7FFF_FFFF, KIND_I32, KIND_F32);
        send_word(64'h0000_0000_8000_0000, KIND_I32, KIND_F64);
        send_word(64'h0000_0000_0000_8000, KIND_I16, KIND_I8);
        send_word(64'h0000_0000_7FC0_0001, KIND_F32, KIND_I32);
        send_word(64'hFFF8_0000_2000_0001, KIND_F64, KIND_F32);
        send_word(64'h47EF_FFFF_F000_0000, KIND_F64, KIND_F32);
        send_word(64'hC7EF_FFFF_E000_0001, KIND_F64, KIND_F32);
        send_word(64'h7FF0_0000_0000_0000, KIND_F64, KIND_F32);
        send_word(64'h0000_0000_FF80_0000, KIND_F32, KIND_F64);
        send_word(64'h0000_0000_7F80_0001, KIND_F32, KIND_F64);
        send_word(64'h0000_0000_0000_0001, KIND_F32, KIND_F64);
        send_word(64'h41DF_FFFF_FFF0_0000, KIND_F64, KIND_I32);
        send_word(64'h41DF_FFFF_FFC0_0000, KIND_F64, KIND_I32);
        send_word(64'hC1E0_0000_0000_0000, KIND_F64, KIND_I32);
        send_word(64'hC1E0_0000_0010_0000, KIND_F64, KIND_I32);
        send_word(64'h3690_0000_0000_0001, KIND_F64, KIND_F32);
        send_word(64'hBFEF_FFFF_FFFF_FFFF, KIND_F64, KIND_I16);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, KIND_F64, KIND_F64);
        send_word(64'h1234_5678_9ABC_DEF0, KIND_BAD, KIND_I8);
        send_word(64'h1234_5678_9ABC_DEF0, KIND_I8, 3'd5);
        send_word(64'h0000_0000_3FFF_FFFF, KIND_F32, KIND_I8);
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            logic [2:0] sk;
            sk = pick_kind();
            if (n == 300) idle_on = 1'b0;
            if (n == 450) idle_on = 1'b1;
            if (n == 600) begin
                i_valid <= 1'b0;
                while (sb.pending.size() != 0) @(posedge i_clk);
            end
            send_word(pick_bits(sk), sk, pick_kind());
        end
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0)
            $display("PASS numeric_format_converter_top");
        else
            $display("FAIL numeric_format_converter_top");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+src
src/nfc_pkg.sv
src/nfc_decode.sv
src/nfc_shift.sv
src/nfc_pack.sv
src/numeric_format_converter_top.sv
test/numeric_format_converter_top_tb.sv
